/* src/assert_macros.svh */
// Assertion helpers shared by the traverse unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("%m: check failed");

// Condition that must hold in the cycle after a trigger
`define ASSERT_NEXT(label, trig, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error("%m: check failed");

`endif

/* src/cbet_pkg.sv */
// Package: widths, codes, curve table and rounding helper of the traverse unit
`timescale 1ns / 1ps
package cbet_pkg;

   localparam int COORD_W   = 32;
   localparam int TIME_W    = 20;
   localparam int ELAPSED_W = 21;
   localparam int IV_W      = 16;
   localparam int T_W       = 17;
   localparam int ACC_W     = 24;
   localparam int REM_W     = 20;
   localparam int QUO_W     = 17;
   localparam int MA_W      = 34;
   localparam int MB_W      = 18;
   localparam int MPR_W     = MA_W + MB_W;
   localparam int MP_W      = 36;
   localparam int CNT_W     = 5;
   localparam int MS_W      = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [T_W-1:0] T_ONE = 17'd65536;

   // input operations
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE    = 3'd4;

   // multiply steps of the shared multiplier
   localparam logic [MS_W-1:0] MS_UU  = 4'd0;
   localparam logic [MS_W-1:0] MS_UT  = 4'd1;
   localparam logic [MS_W-1:0] MS_TT  = 4'd2;
   localparam logic [MS_W-1:0] MS_M1T = 4'd3;
   localparam logic [MS_W-1:0] MS_M2T = 4'd4;
   localparam logic [MS_W-1:0] MS_M3T = 4'd5;
   localparam logic [MS_W-1:0] MS_BZ1 = 4'd6;
   localparam logic [MS_W-1:0] MS_BZ2 = 4'd7;
   localparam logic [MS_W-1:0] MS_SL1 = 4'd8;
   localparam logic [MS_W-1:0] MS_SL2 = 4'd9;
   localparam logic [MS_W-1:0] MS_SL3 = 4'd10;
   localparam logic [MS_W-1:0] MS_POS = 4'd11;

   // sources of the eased ordinate
   localparam logic [1:0] Y_ZERO  = 2'd0;
   localparam logic [1:0] Y_ONE   = 2'd1;
   localparam logic [1:0] Y_CLAMP = 2'd2;

   // control point slots
   localparam logic [1:0] CP_X1 = 2'd0;
   localparam logic [1:0] CP_Y1 = 2'd1;
   localparam logic [1:0] CP_X2 = 2'd2;
   localparam logic [1:0] CP_Y2 = 2'd3;

   // divider step counts
   localparam logic [CNT_W-1:0] FRAC_STEPS = 5'd16;
   localparam logic [CNT_W-1:0] NDIV_STEPS = 5'd17;

   typedef struct packed {
      logic            take;
      logic            y_load;
      logic [1:0]      y_src;
      logic            fdiv_load;
      logic            ndiv_load;
      logic            div_step;
      logic            t_from_frac;
      logic            t_update;
      logic            mul_en;
      logic [MS_W-1:0] mstep;
      logic            yphase;
      logic            out_load;
   } cmd_type;

   typedef struct packed {
      logic hold;
      logic full;
      logic frac_zero;
      logic slope_zero;
      logic n_sat;
   } status_type;

   // control points in Q16, per curve: x1, y1, x2, y2
   function automatic logic [T_W-1:0] curve_point(input logic [1:0] sel,
                                                  input logic [1:0] slot);
      logic [T_W-1:0] v;
      v = '0;
      case ({sel, slot})
         4'b00_00: v = 17'd26214;
         4'b00_01: v = 17'd0;
         4'b00_10: v = 17'd13107;
         4'b01_00: v = 17'd0;
         4'b01_01: v = 17'd0;
         4'b01_10: v = 17'd38011;
         4'b10_00: v = 17'd32768;
         4'b10_01: v = 17'd3277;
         4'b10_10: v = 17'd13107;
         4'b11_00: v = 17'd16384;
         4'b11_01: v = 17'd6554;
         4'b11_10: v = 17'd16384;
         default:  v = T_ONE;
      endcase
      return v;
   endfunction

   // Q16 product rescale, halves away from zero
   function automatic logic signed [MP_W-1:0] mulq(input logic signed [MPR_W-1:0] p);
      logic signed [MPR_W-1:0] m;
      logic signed [MPR_W-1:0] r;
      m = '0;
      if (p >= 0) begin
         r = (p + 52'sd32768) >>> 16;
      end else begin
         m = -p;
         r = -((m + 52'sd32768) >>> 16);
      end
      return r[MP_W-1:0];
   endfunction

endpackage

/* src/cbet_ctrl.sv */
// Controller: sequences time update, divisions, Newton steps and output hand-off
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cbet_ctrl import cbet_pkg::*; #(
   parameter int NEWTON_STEPS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int NS_W = $clog2(NEWTON_STEPS + 1);
   localparam logic [NS_W-1:0] NS_LAST = NS_W'(NEWTON_STEPS - 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PREP = 4'd1;
   localparam logic [3:0] ST_FDIV = 4'd2;
   localparam logic [3:0] ST_FCHK = 4'd3;
   localparam logic [3:0] ST_XMUL = 4'd4;
   localparam logic [3:0] ST_NCHK = 4'd5;
   localparam logic [3:0] ST_NDIV = 4'd6;
   localparam logic [3:0] ST_NUPD = 4'd7;
   localparam logic [3:0] ST_YMUL = 4'd8;
   localparam logic [3:0] ST_YCLP = 4'd9;
   localparam logic [3:0] ST_POS  = 4'd10;
   localparam logic [3:0] ST_DONE = 4'd11;

   logic [3:0]      state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NS_W-1:0] nstep_ff, nstep_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      nstep_in     = nstep_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.mstep    = cnt_ff[MS_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (status.hold) begin
               cmd.y_load = 1'b1;
               cmd.y_src  = Y_ZERO;
               state_in   = ST_POS;
            end else if (status.full) begin
               cmd.y_load = 1'b1;
               cmd.y_src  = Y_ONE;
               state_in   = ST_POS;
            end else begin
               cmd.fdiv_load = 1'b1;
               cnt_in        = '0;
               state_in      = ST_FDIV;
            end
         end
         ST_FDIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == FRAC_STEPS - 5'd1) begin
               state_in = ST_FCHK;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_FCHK: begin
            if (status.frac_zero) begin
               cmd.y_load = 1'b1;
               cmd.y_src  = Y_ZERO;
               state_in   = ST_POS;
            end else begin
               cmd.t_from_frac = 1'b1;
               cnt_in          = '0;
               nstep_in        = '0;
               state_in        = ST_XMUL;
            end
         end
         ST_XMUL: begin
            cmd.mul_en = 1'b1;
            if (cnt_ff == {1'b0, MS_SL3}) begin
               state_in = ST_NCHK;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_NCHK: begin
            cnt_in = '0;
            if (status.slope_zero) begin
               state_in = ST_YMUL;
            end else begin
               cmd.ndiv_load = 1'b1;
               state_in      = status.n_sat ? ST_NUPD : ST_NDIV;
            end
         end
         ST_NDIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == NDIV_STEPS - 5'd1) begin
               state_in = ST_NUPD;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_NUPD: begin
            cmd.t_update = 1'b1;
            cnt_in       = '0;
            if (nstep_ff == NS_LAST) begin
               state_in = ST_YMUL;
            end else begin
               nstep_in = nstep_ff + 1'b1;
               state_in = ST_XMUL;
            end
         end
         ST_YMUL: begin
            cmd.mul_en = 1'b1;
            cmd.yphase = 1'b1;
            if (cnt_ff == {1'b0, MS_BZ2}) begin
               state_in = ST_YCLP;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_YCLP: begin
            cmd.y_load = 1'b1;
            cmd.y_src  = Y_CLAMP;
            state_in   = ST_POS;
         end
         ST_POS: begin
            cmd.mul_en = 1'b1;
            cmd.mstep  = MS_POS;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         nstep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         nstep_ff     <= nstep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEXT(a_take_to_prep, cmd.take, state_ff == ST_PREP)
   `ASSERT_ALWAYS(a_out_free, !cmd.out_load || !rsp_valid_ff || !rsp_stall)
   `ASSERT_ALWAYS(a_nstep_bound, nstep_ff <= NS_LAST)

endmodule

/* src/cbet_datapath.sv */
// Datapath: configuration, elapsed time, shared multiplier and restoring divider
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cbet_datapath import cbet_pkg::*; #(
   parameter int INTERVAL_CAP = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [COORD_W-1:0]        csr_write_data,
   input  logic                      req_operation,
   input  logic [IV_W-1:0]           req_interval,
   input  cmd_type                   cmd,
   output status_type                status,
   output logic signed [COORD_W-1:0] rsp_position,
   output logic                      rsp_moving
);

   localparam logic [IV_W-1:0] CAP = IV_W'(INTERVAL_CAP);

   // configuration registers
   logic signed [COORD_W-1:0] start_ff, start_in, end_ff, end_in;
   logic [TIME_W-1:0]         duration_ff, duration_in, delay_ff, delay_in;
   logic [1:0]                curve_ff, curve_in;

   // traverse state
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 settled_ff, settled_in;
   logic                 moving_ff, moving_in;

   // arithmetic registers
   logic [T_W-1:0]           t_ff, t_in, frac_ff, frac_in, y_ff, y_in;
   logic [T_W-1:0]           m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in;
   logic [T_W-1:0]           ta_ff, ta_in, tb_ff, tb_in, tc_ff, tc_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, sl_ff, sl_in;
   logic signed [COORD_W-1:0] pos_ff, pos_in;
   logic [REM_W-1:0]         rem_ff, rem_in, div_ff, div_in;
   logic [QUO_W-1:0]         quo_ff, quo_in, tail_ff, tail_in;
   logic                     sat_ff, sat_in, neg_ff, neg_in;
   logic signed [COORD_W-1:0] out_pos_ff, out_pos_in;
   logic                     out_mov_ff, out_mov_in;

   // combinational helpers
   logic [TIME_W-1:0]      dur_eff;
   logic [ELAPSED_W-1:0]   limit, diff;
   logic [IV_W-1:0]        iv_sat;
   logic [ELAPSED_W:0]     e_sum;
   logic [REM_W:0]         r2, r2_sub;
   logic                   r2_ge;
   logic [ACC_W-1:0]       n_mag, d_mag;
   logic                   n_sat;
   logic [T_W:0]           t_plus;
   logic [T_W-1:0]         u, p1, p2, onemp2;
   logic signed [MB_W-1:0] p2mp1;
   logic signed [COORD_W:0] span;
   logic signed [MA_W-1:0] opa;
   logic signed [MB_W-1:0] opb;
   logic signed [MPR_W-1:0] prod;
   logic signed [MP_W-1:0] pq;
   logic signed [ACC_W-1:0] p24, p24x3;

   // configuration writes
   always_comb begin
      start_in    = start_ff;
      end_in      = end_ff;
      duration_in = duration_ff;
      delay_in    = delay_ff;
      curve_in    = curve_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START:    start_in    = csr_write_data;
            CSR_END:      end_in      = csr_write_data;
            CSR_DURATION: duration_in = csr_write_data[TIME_W-1:0];
            CSR_DELAY:    delay_in    = csr_write_data[TIME_W-1:0];
            CSR_CURVE:    curve_in    = csr_write_data[1:0];
            default:      ;
         endcase
      end
   end

   // time bookkeeping
   assign dur_eff = (duration_ff == '0) ? TIME_W'(1) : duration_ff;
   assign limit   = {1'b0, delay_ff} + {1'b0, dur_eff};
   assign iv_sat  = (req_interval > CAP) ? CAP : req_interval;
   assign e_sum   = {1'b0, elapsed_ff} + {6'b0, iv_sat};
   assign diff    = elapsed_ff - {1'b0, delay_ff};

   always_comb begin
      elapsed_in = elapsed_ff;
      settled_in = settled_ff;
      moving_in  = moving_ff;
      if (cmd.take) begin
         if (req_operation == OP_START) begin
            elapsed_in = '0;
            settled_in = 1'b0;
            moving_in  = 1'b1;
         end else if (settled_ff) begin
            moving_in = 1'b0;
         end else if (e_sum >= {1'b0, limit}) begin
            elapsed_in = limit;
            settled_in = 1'b1;
            moving_in  = 1'b0;
         end else begin
            elapsed_in = e_sum[ELAPSED_W-1:0];
            moving_in  = 1'b1;
         end
      end
   end

   // restoring divider, one quotient bit a cycle
   assign r2     = {rem_ff, tail_ff[QUO_W-1]};
   assign r2_sub = r2 - {1'b0, div_ff};
   assign r2_ge  = (r2 >= {1'b0, div_ff});
   assign n_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign d_mag  = sl_ff[ACC_W-1] ? ACC_W'(-sl_ff) : ACC_W'(sl_ff);
   assign n_sat  = ({1'b0, n_mag} >= {d_mag, 1'b0});

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      tail_in = tail_ff;
      sat_in  = sat_ff;
      neg_in  = neg_ff;
      if (cmd.fdiv_load) begin
         rem_in  = diff[REM_W-1:0];
         div_in  = dur_eff;
         quo_in  = '0;
         tail_in = '0;
      end else if (cmd.ndiv_load) begin
         rem_in  = n_mag[REM_W:1];
         div_in  = d_mag[REM_W-1:0];
         quo_in  = '0;
         tail_in = {n_mag[0], 16'b0};
         sat_in  = n_sat;
         neg_in  = acc_ff[ACC_W-1] ^ sl_ff[ACC_W-1];
      end else if (cmd.div_step) begin
         rem_in  = r2_ge ? r2_sub[REM_W-1:0] : r2[REM_W-1:0];
         tail_in = {tail_ff[QUO_W-2:0], 1'b0};
         quo_in  = {quo_ff[QUO_W-2:0], r2_ge};
      end
   end

   // shared multiplier operands
   assign u      = T_ONE - t_ff;
   assign p1     = curve_point(curve_ff, cmd.yphase ? CP_Y1 : CP_X1);
   assign p2     = curve_point(curve_ff, cmd.yphase ? CP_Y2 : CP_X2);
   assign p2mp1  = $signed({1'b0, p2}) - $signed({1'b0, p1});
   assign onemp2 = T_ONE - p2;
   assign span   = $signed({end_ff[COORD_W-1], end_ff})
                 - $signed({start_ff[COORD_W-1], start_ff});

   always_comb begin
      opa = '0;
      opb = '0;
      unique case (cmd.mstep)
         MS_UU:  begin opa = $signed({17'b0, u});     opb = $signed({1'b0, u});      end
         MS_UT:  begin opa = $signed({17'b0, u});     opb = $signed({1'b0, t_ff});   end
         MS_TT:  begin opa = $signed({17'b0, t_ff});  opb = $signed({1'b0, t_ff});   end
         MS_M1T: begin opa = $signed({17'b0, m1_ff}); opb = $signed({1'b0, t_ff});   end
         MS_M2T: begin opa = $signed({17'b0, m2_ff}); opb = $signed({1'b0, t_ff});   end
         MS_M3T: begin opa = $signed({17'b0, m3_ff}); opb = $signed({1'b0, t_ff});   end
         MS_BZ1: begin opa = $signed({17'b0, ta_ff}); opb = $signed({1'b0, p1});     end
         MS_BZ2: begin opa = $signed({17'b0, tb_ff}); opb = $signed({1'b0, p2});     end
         MS_SL1: begin opa = $signed({17'b0, m1_ff}); opb = $signed({1'b0, p1});     end
         MS_SL2: begin opa = $signed({17'b0, m2_ff}); opb = p2mp1;                   end
         MS_SL3: begin opa = $signed({17'b0, m3_ff}); opb = $signed({1'b0, onemp2}); end
         MS_POS: begin opa = $signed({span[COORD_W], span}); opb = $signed({1'b0, y_ff}); end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   assign prod  = opa * opb;
   assign pq    = mulq(prod);
   assign p24   = pq[ACC_W-1:0];
   assign p24x3 = (p24 <<< 1) + p24;

   // write back the product
   always_comb begin
      m1_in  = m1_ff;
      m2_in  = m2_ff;
      m3_in  = m3_ff;
      ta_in  = ta_ff;
      tb_in  = tb_ff;
      tc_in  = tc_ff;
      acc_in = acc_ff;
      sl_in  = sl_ff;
      pos_in = pos_ff;
      if (cmd.mul_en) begin
         case (cmd.mstep)
            MS_UU:  m1_in = pq[T_W-1:0];
            MS_UT:  m2_in = pq[T_W-1:0];
            MS_TT:  m3_in = pq[T_W-1:0];
            MS_M1T: ta_in = pq[T_W-1:0];
            MS_M2T: tb_in = pq[T_W-1:0];
            MS_M3T: tc_in = pq[T_W-1:0];
            MS_BZ1: acc_in = p24x3 + $signed({7'b0, tc_ff});
            MS_BZ2: acc_in = acc_ff + p24x3
                           - (cmd.yphase ? ACC_W'(0) : $signed({7'b0, frac_ff}));
            MS_SL1: sl_in = p24x3;
            MS_SL2: sl_in = sl_ff + (p24x3 <<< 1);
            MS_SL3: sl_in = sl_ff + p24x3;
            MS_POS: pos_in = start_ff + pq[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // parameter, fraction and ordinate
   assign t_plus = {1'b0, t_ff} + {1'b0, quo_ff};

   always_comb begin
      t_in    = t_ff;
      frac_in = frac_ff;
      y_in    = y_ff;
      if (cmd.t_from_frac) begin
         t_in    = {1'b0, quo_ff[15:0]};
         frac_in = {1'b0, quo_ff[15:0]};
      end else if (cmd.t_update) begin
         if (neg_ff) begin
            t_in = (sat_ff || t_plus > {1'b0, T_ONE}) ? T_ONE : t_plus[T_W-1:0];
         end else begin
            t_in = (sat_ff || quo_ff > t_ff) ? '0 : t_ff - quo_ff;
         end
      end
      if (cmd.y_load) begin
         case (cmd.y_src)
            Y_ZERO: y_in = '0;
            Y_ONE:  y_in = T_ONE;
            default: begin
               if (acc_ff < 0) begin
                  y_in = '0;
               end else if (acc_ff > $signed({7'b0, T_ONE})) begin
                  y_in = T_ONE;
               end else begin
                  y_in = acc_ff[T_W-1:0];
               end
            end
         endcase
      end
   end

   // output register
   always_comb begin
      out_pos_in = out_pos_ff;
      out_mov_in = out_mov_ff;
      if (cmd.out_load) begin
         out_pos_in = pos_ff;
         out_mov_in = moving_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         end_ff      <= '0;
         duration_ff <= TIME_W'(16);
         delay_ff    <= '0;
         curve_ff    <= '0;
         elapsed_ff  <= ELAPSED_W'(16);
         settled_ff  <= 1'b1;
         moving_ff   <= 1'b0;
         t_ff        <= '0;
         y_ff        <= '0;
      end else begin
         start_ff    <= start_in;
         end_ff      <= end_in;
         duration_ff <= duration_in;
         delay_ff    <= delay_in;
         curve_ff    <= curve_in;
         elapsed_ff  <= elapsed_in;
         settled_ff  <= settled_in;
         moving_ff   <= moving_in;
         t_ff        <= t_in;
         y_ff        <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff    <= frac_in;
      m1_ff      <= m1_in;
      m2_ff      <= m2_in;
      m3_ff      <= m3_in;
      ta_ff      <= ta_in;
      tb_ff      <= tb_in;
      tc_ff      <= tc_in;
      acc_ff     <= acc_in;
      sl_ff      <= sl_in;
      pos_ff     <= pos_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      quo_ff     <= quo_in;
      tail_ff    <= tail_in;
      sat_ff     <= sat_in;
      neg_ff     <= neg_in;
      out_pos_ff <= out_pos_in;
      out_mov_ff <= out_mov_in;
   end

   assign status.hold       = (elapsed_ff <= {1'b0, delay_ff});
   assign status.full       = (diff >= {1'b0, dur_eff});
   assign status.frac_zero  = (quo_ff[15:0] == '0);
   assign status.slope_zero = (sl_ff == '0);
   assign status.n_sat      = n_sat;

   assign rsp_position = out_pos_ff;
   assign rsp_moving   = out_mov_ff;

   `ASSERT_ALWAYS(a_t_range, t_ff <= T_ONE)
   `ASSERT_ALWAYS(a_y_range, y_ff <= T_ONE)
   `ASSERT_NEXT(a_start_clears, cmd.take && req_operation == OP_START, elapsed_ff == '0 && !settled_ff)

endmodule

/* src/cubic_bezier_eased_traverse_unit.sv */
// Top level: eased traverse of one coordinate along a cubic-bezier curve
//
// Usage: program start_value, end_value, duration, delay and curve_select
// through the csr_ write port (index 0..4) while the unit is idle. Each
// request transfer is either a start (operation 1) or a tick (operation 0)
// carrying an interval in 1/16 ms, capped at INTERVAL_CAP. Every request
// gives exactly one response transfer: the eased position (Q16.16) and the
// moving flag.
// Requests in the hold phase or at the end of the traverse skip the curve
// solve. While the curve is solved, the time taken is set by the single
// shared multiplier, stepped through the bezier terms, and the
// one-bit-a-cycle divider used for the fraction and for the Newton
// corrections. One request is worked on at a time; req_stall stays high
// until its result sits in the output register, and the next request can
// be taken in that same cycle.
// Reset: configuration returns to its defaults, the traverse is settled at
// its end and no response is pending. A stalled response holds its value;
// the unit still takes the next request and parks the new result until the
// output register is free.
`timescale 1ns / 1ps
module cubic_bezier_eased_traverse_unit import cbet_pkg::*; #(
   parameter int NEWTON_STEPS = 4,
   parameter int INTERVAL_CAP = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [COORD_W-1:0]        csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_operation,
   input  logic [IV_W-1:0]           req_interval,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_position,
   output logic                      rsp_moving
);

   cmd_type    cmd;
   status_type status;

   cbet_ctrl #(
      .NEWTON_STEPS(NEWTON_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cbet_datapath #(
      .INTERVAL_CAP(INTERVAL_CAP)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_operation),
      .req_interval     (req_interval),
      .cmd              (cmd),
      .status           (status),
      .rsp_position     (rsp_position),
      .rsp_moving       (rsp_moving)
   );

endmodule
